@@ sv/msr_pkg.sv @@
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types, widths, codes and the residue mapping for the sequence
// reweighting block.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned CODE_W = 5;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned WGT_W  = 17;
  localparam int unsigned NEFF_W = 25;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned REG_W  = 9;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned RES_W  = 8;
  localparam int unsigned ROWQ_W = 8;

  localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [IDX_W-1:0] CFG_NUM_COLS  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_NUM_ROWS  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [REG_W-1:0] COLS_RESET = 9'd256;
  localparam logic [REG_W-1:0] ROWS_RESET = 9'd256;
  localparam logic [CFG_W-1:0] THR_RESET  = 17'd52429;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_Q_RD,
    OP_Q_DIV,
    OP_INIT_START,
    OP_INIT,
    OP_ROW_RD,
    OP_ROW_SET,
    OP_COL,
    OP_EVAL,
    OP_J_WR,
    OP_J_NEXT,
    OP_ROW_END,
    OP_ROW_ACC,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ZERO,
    OUT_QUERY
  } out_sel_e;

  typedef struct packed {
    dp_op_e   op;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_pos;
    logic query_ok;
    logic i_last;
    logic j_last;
    logic col_last;
    logic neighbour;
    logic div_busy;
  } stat_t;

  function automatic logic [CODE_W-1:0] residue_code(input logic [RES_W-1:0] ch);
    logic [CODE_W-1:0] code;
    code = '0;
    unique case (ch)
      8'h41: code = 5'd1;
      8'h43: code = 5'd2;
      8'h44: code = 5'd3;
      8'h45: code = 5'd4;
      8'h46: code = 5'd5;
      8'h47: code = 5'd6;
      8'h48: code = 5'd7;
      8'h49: code = 5'd8;
      8'h4B: code = 5'd9;
      8'h4C: code = 5'd10;
      8'h4D: code = 5'd11;
      8'h4E: code = 5'd12;
      8'h50: code = 5'd13;
      8'h51: code = 5'd14;
      8'h52: code = 5'd15;
      8'h53: code = 5'd16;
      8'h54: code = 5'd17;
      8'h56: code = 5'd18;
      8'h57: code = 5'd19;
      8'h59: code = 5'd20;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

@@ sv/msr_div.sv @@
// ----------------------------------------------------------------------------
// msr_div
// Restoring divider for 65536 / count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msr_div
  import msr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [WGT_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(WGT_W + 1);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W:0]    rem_q;
  logic [WGT_W-1:0]  dvd_q;
  logic [WGT_W-1:0]  quot_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem_q[CNT_W-1:0], dvd_q[WGT_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(WGT_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dvd_q  <= ONE_Q16;
      quot_q <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      dvd_q  <= {dvd_q[WGT_W-2:0], 1'b0};
      quot_q <= {quot_q[WGT_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

@@ sv/msr_datapath.sv @@
// ----------------------------------------------------------------------------
// msr_datapath
// Configuration, residue store, count store, pair compare, weight sum and
// result register.
// ----------------------------------------------------------------------------
module msr_datapath
  import msr_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic [RES_W-1:0]  residue_i,
  input  logic [ROWQ_W-1:0] row_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              out_done_res_o,
  output logic [CNT_W-1:0]  out_neighbour_count_o,
  output logic [WGT_W-1:0]  out_weight_o,
  output logic [NEFF_W-1:0] out_neff_o
);

  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned RN_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CN_W   = $clog2(MAX_COLS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_ROWS * MAX_COLS) > 0 ?
                                   $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int unsigned TOT_W  = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int unsigned CMP_W  = RN_W > ROWQ_W ? RN_W : ROWQ_W;
  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;

  logic [REG_W-1:0]  cols_q, rows_q;
  logic [CFG_W-1:0]  thr_q;
  logic [TOT_W-1:0]  pos_q;
  logic              valid_q, valid_d;
  logic [NEFF_W-1:0] neff_q, neff_d;
  logic [RN_W-1:0]   i_q, j_q;
  logic [CN_W-1:0]   c_q, match_q;
  logic [TOT_W-1:0]  base_i_q, base_j_q;
  logic              rd_vld_q;
  logic [CNT_W-1:0]  cnt_i_q;
  logic [NEFF_W-1:0] sum_q;
  logic              out_valid_q, out_done_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [WGT_W-1:0]  out_wgt_q;
  logic [NEFF_W-1:0] out_neff_q;

  logic [31:0]        cols_ext, rows_ext;
  logic [CN_W-1:0]    eff_c;
  logic [RN_W-1:0]    eff_r;
  logic [RN_W+CN_W-1:0] prod;
  logic [TOT_W-1:0]   total;
  logic [CFG_W+CN_W-1:0] thr_nc;
  logic [CMP_W-1:0]   row_x;
  logic               out_free;
  logic               cfg_hit;

  logic [CODE_W-1:0]  store [DEPTH];
  logic [CODE_W-1:0]  code_a_q, code_b_q;
  logic [CNT_W-1:0]   counts [MAX_ROWS];
  logic [CNT_W-1:0]   cnt_rd_q;
  logic [ROW_W-1:0]   cnt_ra, cnt_wa;
  logic               cnt_we;
  logic [CNT_W-1:0]   cnt_wd, cnt_j_inc, cnt_i_inc;
  logic [NEFF_W:0]    sum_add;
  logic               div_start, div_busy;
  logic [CNT_W-1:0]   div_dvs;
  logic [WGT_W-1:0]   div_quot;

  assign cols_ext = 32'(cols_q);
  assign rows_ext = 32'(rows_q);

  always_comb begin
    if (cols_q == '0) begin
      eff_c = CN_W'(1);
    end else if (cols_ext > MAX_COLS) begin
      eff_c = CN_W'(MAX_COLS);
    end else begin
      eff_c = cols_ext[CN_W-1:0];
    end
    if (rows_q == '0) begin
      eff_r = RN_W'(1);
    end else if (rows_ext > MAX_ROWS) begin
      eff_r = RN_W'(MAX_ROWS);
    end else begin
      eff_r = rows_ext[RN_W-1:0];
    end
  end

  assign prod   = eff_r * eff_c;
  assign total  = prod[TOT_W-1:0];
  assign thr_nc = thr_q * eff_c;
  assign row_x  = CMP_W'(row_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_hit  = cfg_we_i && (cfg_idx_i == CFG_NUM_COLS || cfg_idx_i == CFG_NUM_ROWS ||
                                 cfg_idx_i == CFG_THRESHOLD);

  assign cnt_j_inc = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;
  assign cnt_i_inc = (cnt_i_q == '1) ? cnt_i_q : cnt_i_q + 1'b1;
  assign sum_add   = {1'b0, sum_q} + (NEFF_W + 1)'(div_quot);

  assign stat_o.out_free  = out_free;
  assign stat_o.last_pos  = (pos_q + 1'b1) == total;
  assign stat_o.query_ok  = valid_q && (row_x < CMP_W'(eff_r));
  assign stat_o.i_last    = i_q == eff_r - 1'b1;
  assign stat_o.j_last    = j_q == eff_r - 1'b1;
  assign stat_o.col_last  = c_q == eff_c - 1'b1;
  assign stat_o.neighbour = {match_q, 16'b0} >= thr_nc;
  assign stat_o.div_busy  = div_busy;

  always_comb begin
    valid_d = valid_q;
    neff_d  = neff_q;
    if (cmd_i.op == OP_LOAD && pos_q == '0) begin
      valid_d = 1'b0;
    end
    if (cmd_i.op == OP_FINISH) begin
      valid_d = 1'b1;
      neff_d  = sum_q;
    end
    if (cfg_hit) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    cnt_ra    = i_q[ROW_W-1:0];
    cnt_we    = 1'b0;
    cnt_wa    = i_q[ROW_W-1:0];
    cnt_wd    = cnt_i_q;
    div_start = 1'b0;
    div_dvs   = cnt_i_q;
    unique case (cmd_i.op)
      OP_Q_RD: cnt_ra = row_x[ROW_W-1:0];
      OP_EVAL: cnt_ra = j_q[ROW_W-1:0];
      OP_INIT: begin
        cnt_we = 1'b1;
        cnt_wd = CNT_W'(1);
      end
      OP_J_WR: begin
        cnt_we = 1'b1;
        cnt_wa = j_q[ROW_W-1:0];
        cnt_wd = cnt_j_inc;
      end
      OP_ROW_END: begin
        cnt_we    = 1'b1;
        div_start = 1'b1;
      end
      OP_Q_DIV: begin
        div_start = 1'b1;
        div_dvs   = cnt_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      store[pos_q[ADDR_W-1:0]] <= residue_code(residue_i);
    end
    code_a_q <= store[ADDR_W'(base_i_q + TOT_W'(c_q))];
    code_b_q <= store[ADDR_W'(base_j_q + TOT_W'(c_q))];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      counts[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= counts[cnt_ra];
  end

  msr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (div_dvs),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= COLS_RESET;
      rows_q      <= ROWS_RESET;
      thr_q       <= THR_RESET;
      pos_q       <= '0;
      valid_q     <= 1'b0;
      neff_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      neff_q   <= neff_d;
      rd_vld_q <= cmd_i.op == OP_COL;
      if (cfg_hit) begin
        pos_q <= '0;
      end else if (cmd_i.op == OP_LOAD) begin
        pos_q <= stat_o.last_pos ? '0 : pos_q + 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NUM_COLS:  cols_q <= cfg_data_i[REG_W-1:0];
          CFG_NUM_ROWS:  rows_q <= cfg_data_i[REG_W-1:0];
          CFG_THRESHOLD: thr_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.out_sel != OUT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && code_a_q == code_b_q) begin
      match_q <= match_q + 1'b1;
    end
    unique case (cmd_i.op)
      OP_INIT_START: begin
        i_q      <= '0;
        base_i_q <= '0;
        sum_q    <= '0;
      end
      OP_INIT: i_q <= stat_o.i_last ? '0 : i_q + 1'b1;
      OP_ROW_SET: begin
        cnt_i_q  <= cnt_rd_q;
        j_q      <= i_q + 1'b1;
        base_j_q <= base_i_q + TOT_W'(eff_c);
        c_q      <= '0;
        match_q  <= '0;
      end
      OP_COL: c_q <= c_q + 1'b1;
      OP_EVAL: begin
        if (stat_o.neighbour) begin
          cnt_i_q <= cnt_i_inc;
        end
      end
      OP_J_NEXT: begin
        j_q      <= j_q + 1'b1;
        base_j_q <= base_j_q + TOT_W'(eff_c);
        c_q      <= '0;
        match_q  <= '0;
      end
      OP_ROW_ACC: begin
        sum_q    <= sum_add[NEFF_W] ? '1 : sum_add[NEFF_W-1:0];
        i_q      <= i_q + 1'b1;
        base_i_q <= base_i_q + TOT_W'(eff_c);
      end
      OP_Q_DIV: cnt_i_q <= cnt_rd_q;
      default: ;
    endcase
    unique case (cmd_i.out_sel)
      OUT_ZERO: begin
        out_done_q <= valid_d;
        out_cnt_q  <= '0;
        out_wgt_q  <= '0;
        out_neff_q <= valid_d ? neff_d : '0;
      end
      OUT_QUERY: begin
        out_done_q <= valid_q;
        out_cnt_q  <= cnt_i_q;
        out_wgt_q  <= div_quot;
        out_neff_q <= neff_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o           = out_valid_q;
  assign out_done_res_o        = out_done_q;
  assign out_neighbour_count_o = out_cnt_q;
  assign out_weight_o          = out_wgt_q;
  assign out_neff_o            = out_neff_q;

endmodule

@@ sv/msr_ctrl.sv @@
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer for loading, queries and the pairwise compute pass.
// ----------------------------------------------------------------------------
module msr_ctrl
  import msr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_func_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_QRD,
    S_QDIV,
    S_CSTART,
    S_INIT,
    S_ROWRD,
    S_ROWSET,
    S_COL,
    S_DRAIN,
    S_EVAL,
    S_JWR,
    S_JNEXT,
    S_ROWEND,
    S_ROWDIV,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.out_sel = OUT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (!in_func_i) begin
            cmd_o.op = OP_LOAD;
            if (stat_i.last_pos) begin
              state_d = S_CSTART;
            end else begin
              cmd_o.out_sel = OUT_ZERO;
            end
          end else if (stat_i.query_ok) begin
            cmd_o.op = OP_Q_RD;
            state_d  = S_QRD;
          end else begin
            cmd_o.out_sel = OUT_ZERO;
          end
        end
      end
      S_QRD: begin
        cmd_o.op = OP_Q_DIV;
        state_d  = S_QDIV;
      end
      S_QDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.out_sel = OUT_QUERY;
          state_d       = S_IDLE;
        end
      end
      S_CSTART: begin
        cmd_o.op = OP_INIT_START;
        state_d  = S_INIT;
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (stat_i.i_last) begin
          state_d = S_ROWRD;
        end
      end
      S_ROWRD: begin
        cmd_o.op = OP_ROW_RD;
        state_d  = S_ROWSET;
      end
      S_ROWSET: begin
        cmd_o.op = OP_ROW_SET;
        state_d  = stat_i.i_last ? S_ROWEND : S_COL;
      end
      S_COL: begin
        cmd_o.op = OP_COL;
        if (stat_i.col_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.op = OP_EVAL;
        state_d  = stat_i.neighbour ? S_JWR : S_JNEXT;
      end
      S_JWR: begin
        cmd_o.op = OP_J_WR;
        state_d  = S_JNEXT;
      end
      S_JNEXT: begin
        cmd_o.op = OP_J_NEXT;
        state_d  = stat_i.j_last ? S_ROWEND : S_COL;
      end
      S_ROWEND: begin
        cmd_o.op = OP_ROW_END;
        state_d  = S_ROWDIV;
      end
      S_ROWDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_ROW_ACC;
          state_d  = stat_i.i_last ? S_FIN : S_ROWRD;
        end
      end
      S_FIN: begin
        cmd_o.op      = OP_FINISH;
        cmd_o.out_sel = OUT_ZERO;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/msa_sequence_reweighting.sv @@
// ----------------------------------------------------------------------------
// msa_sequence_reweighting
// Effective sequence count of an alignment: neighbour counts, weights, neff.
// ----------------------------------------------------------------------------
// Usage: write num_cols, num_rows and identity_threshold on the cfg port
// (any write to them restarts loading). Send items on the in channel: func 0
// loads the next residue in row-major order, func 1 queries one row. Each item
// returns exactly one result on the out channel.
// A load's result is registered in the cycle after it is taken, except for
// the last residue; while idle and while the result register drains, a new
// item is taken every cycle. The last residue of the alignment starts the
// compute pass: a count init sweep over all rows, then for each row a count
// read, for each pair of rows a compare over the residue store ports (and a
// count write for a neighbour), and a weight division. A query does a count
// read and a division; one out of range or before compute is answered
// without them. Reset clears the loading position, the weights-valid flag,
// neff and the result valid flag; the residue store is not cleared. When the
// receiver stalls the result is held and no new item is taken.
// ----------------------------------------------------------------------------
module msa_sequence_reweighting
  import msr_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_func_i,
  input  logic [RES_W-1:0]  in_residue_i,
  input  logic [ROWQ_W-1:0] in_row_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_done_res_o,
  output logic [CNT_W-1:0]  out_neighbour_count_o,
  output logic [WGT_W-1:0]  out_weight_o,
  output logic [NEFF_W-1:0] out_neff_o
);

  cmd_t  cmd;
  stat_t stat;

  msr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_func_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  msr_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .residue_i             (in_residue_i),
    .row_i                 (in_row_i),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .out_done_res_o        (out_done_res_o),
    .out_neighbour_count_o (out_neighbour_count_o),
    .out_weight_o          (out_weight_o),
    .out_neff_o            (out_neff_o)
  );

endmodule

@@ verif/msr_checker.sv @@
// ----------------------------------------------------------------------------
// msr_checker
// Watches the configuration port and both channels of the sequence
// reweighting block, predicts every result from accepted items and compares
// each delivered result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module msr_checker
  import msr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              in_func_i,
  input  logic [RES_W-1:0]  in_residue_i,
  input  logic [ROWQ_W-1:0] in_row_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              out_done_res_i,
  input  logic [CNT_W-1:0]  out_neighbour_count_i,
  input  logic [WGT_W-1:0]  out_weight_i,
  input  logic [NEFF_W-1:0] out_neff_i,
  output int                fail_cnt_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS_MAX = 256;
  localparam int unsigned COLS_MAX = 256;

  typedef struct packed {
    logic              done;
    logic [CNT_W-1:0]  cnt;
    logic [WGT_W-1:0]  wgt;
    logic [NEFF_W-1:0] neff;
  } result_t;

  result_t           want_q[$];
  logic [CODE_W-1:0] codes[ROWS_MAX*COLS_MAX];
  int unsigned       counts[ROWS_MAX];
  int unsigned       load_pos;
  int unsigned       neff_acc;
  bit                weights_ok;
  logic [REG_W-1:0]  cols_r;
  logic [REG_W-1:0]  rows_r;
  logic [CFG_W-1:0]  thr_r;
  int                fails;

  assign fail_cnt_o = fails;

  initial fails = 0;

  function automatic logic [CODE_W-1:0] amino_code(input logic [RES_W-1:0] ch);
    string letters;
    letters = "ACDEFGHIKLMNPQRSTVWY";
    for (int k = 0; k < 20; k++) begin
      if (letters[k] == ch) return CODE_W'(k + 1);
    end
    return '0;
  endfunction

  function automatic int unsigned clamp_dim(input logic [REG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic count_neighbours();
    int unsigned nc;
    int unsigned nr;
    longint      m;
    longint      sum;
    nc = clamp_dim(cols_r, COLS_MAX);
    nr = clamp_dim(rows_r, ROWS_MAX);
    for (int i = 0; i < nr; i++) counts[i] = 1;
    for (int i = 0; i < nr; i++) begin
      for (int j = i + 1; j < nr; j++) begin
        m = 0;
        for (int c = 0; c < nc; c++) begin
          if (codes[i*nc+c] == codes[j*nc+c]) m++;
        end
        if (m * 65536 >= longint'(thr_r) * nc) begin
          if (counts[i] < 511) counts[i]++;
          if (counts[j] < 511) counts[j]++;
        end
      end
    end
    sum = 0;
    for (int i = 0; i < nr; i++) sum += 65536 / counts[i];
    neff_acc   = (sum > 33554431) ? 33554431 : int'(sum);
    weights_ok = 1'b1;
  endtask

  task automatic report(input string what, input longint got, input longint exp);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
    fails++;
  endtask

  always @(posedge clk_i) begin
    result_t     r;
    result_t     w;
    int unsigned total;
    if (!rst_ni) begin
      want_q.delete();
      load_pos   = 0;
      neff_acc   = 0;
      weights_ok = 1'b0;
      cols_r     = COLS_RESET;
      rows_r     = ROWS_RESET;
      thr_r      = THR_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_COLS: begin
            cols_r = cfg_data_i[REG_W-1:0];
            load_pos = 0;
            weights_ok = 1'b0;
          end
          CFG_NUM_ROWS: begin
            rows_r = cfg_data_i[REG_W-1:0];
            load_pos = 0;
            weights_ok = 1'b0;
          end
          CFG_THRESHOLD: begin
            thr_r = cfg_data_i;
            load_pos = 0;
            weights_ok = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        r = '0;
        if (!in_func_i) begin
          total = clamp_dim(rows_r, ROWS_MAX) * clamp_dim(cols_r, COLS_MAX);
          if (load_pos >= total) load_pos = 0;
          if (load_pos == 0) weights_ok = 1'b0;
          codes[load_pos] = amino_code(in_residue_i);
          load_pos++;
          if (load_pos >= total) begin
            load_pos = 0;
            count_neighbours();
          end
        end else if (weights_ok && in_row_i < clamp_dim(rows_r, ROWS_MAX)) begin
          r.cnt = CNT_W'(counts[in_row_i]);
          r.wgt = WGT_W'(65536 / counts[in_row_i]);
        end
        r.done = weights_ok;
        r.neff = weights_ok ? NEFF_W'(neff_acc) : '0;
        want_q.push_back(r);
      end
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          w = want_q.pop_front();
          if (out_done_res_i != w.done) report("done_res", out_done_res_i, w.done);
          if (out_neighbour_count_i != w.cnt)
            report("neighbour_count", out_neighbour_count_i, w.cnt);
          if (out_weight_i != w.wgt) report("weight", out_weight_i, w.wgt);
          if (out_neff_i != w.neff) report("neff", out_neff_i, w.neff);
        end
      end
    end
    pending_o <= want_q.size();
  end

endmodule

@@ verif/msa_sequence_reweighting_tb.sv @@
// ----------------------------------------------------------------------------
// msa_sequence_reweighting_tb
// Loads alignments of many shapes and thresholds, queries rows before, during
// and after loading, and lets the checker compare every result while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module msa_sequence_reweighting_tb;
  import msr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              in_func_i = 1'b0;
  logic [RES_W-1:0]  in_residue_i = '0;
  logic [ROWQ_W-1:0] in_row_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              out_done_res_o;
  logic [CNT_W-1:0]  out_neighbour_count_o;
  logic [WGT_W-1:0]  out_weight_o;
  logic [NEFF_W-1:0] out_neff_o;
  int                fail_cnt;
  int                pending;
  logic              in_taken = 1'b0;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                sent = 0;

  always #5 clk_i = ~clk_i;

  msa_sequence_reweighting i_dut (.*);

  msr_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_func_i, .in_residue_i, .in_row_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_done_res_i(out_done_res_o),
    .out_neighbour_count_i(out_neighbour_count_o), .out_weight_i(out_weight_o),
    .out_neff_i(out_neff_o), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) in_taken <= in_valid_i && in_ready_o;

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  initial begin
    #20ms;
    $display("msa_sequence_reweighting regression: fail");
    $finish;
  end

  task automatic send_item(input logic func, input logic [7:0] res, input logic [7:0] row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_func_i    <= func;
    in_residue_i <= res;
    in_row_i     <= row;
    do @(negedge clk_i); while (!in_taken);
    sent++;
  endtask

  // drain, then hold a quiet gap so the port is idle before writing
  task automatic configure(input logic [8:0] cols, input logic [8:0] rows,
                           input logic [16:0] thr);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_NUM_COLS;
    cfg_data_i <= {8'($urandom), cols};
    @(negedge clk_i);
    cfg_idx_i <= CFG_NUM_ROWS;
    cfg_data_i <= {8'($urandom), rows};
    @(negedge clk_i);
    cfg_idx_i <= CFG_THRESHOLD;
    cfg_data_i <= thr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_letter();
    string letters;
    letters = "ACDEFGHIKLMNPQRSTVWY";
    return letters[$urandom_range(19)];
  endfunction

  // load one alignment of noisy near-copies of a base row; broken stops early
  task automatic load_alignment(input int nr, input int nc, input int mut_pct,
                                input bit broken);
    logic [7:0] base[256];
    logic [7:0] ch;
    int         stop_at;
    stop_at = broken ? $urandom_range(nr*nc - 1) : nr*nc;
    for (int c = 0; c < nc; c++) base[c] = pick_letter();
    for (int k = 0; k < stop_at; k++) begin
      ch = base[k % nc];
      if ($urandom_range(99) < mut_pct) ch = pick_letter();
      if ($urandom_range(99) < 5) ch = 8'($urandom);
      if ($urandom_range(99) < 3) ch = "-";
      send_item(1'b0, ch, 8'($urandom));
      if ($urandom_range(99) < 2) send_item(1'b1, 8'($urandom), 8'($urandom_range(nr)));
    end
  endtask

  task automatic ask_rows(input int nr, input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) send_item(1'b1, 8'($urandom), 8'($urandom));
      else send_item(1'b1, 8'($urandom), 8'($urandom_range(nr - 1)));
    end
  endtask

  function automatic logic [16:0] pick_threshold();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(131071, 65537));
      3: return 17'($urandom_range(65536));
      default: return 17'($urandom_range(60000, 30000));
    endcase
  endfunction

  initial begin
    logic [7:0] dir_res[12];
    int         nr;
    int         nc;
    int         ph;
    dir_res = '{"A", "Y", "-", "a", 8'h00, 8'hFF, "A", "Y", "-", "a", 8'h00, "B"};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(1'b1, 8'h00, 8'h00);
    send_item(1'b1, 8'hFF, 8'hFF);
    configure(9'd4, 9'd3, 17'd65536);
    for (int k = 0; k < 12; k++) send_item(1'b0, dir_res[k], 8'h00);
    send_item(1'b1, 8'h00, 8'd0);
    send_item(1'b1, 8'h00, 8'd1);
    send_item(1'b1, 8'h00, 8'd2);
    send_item(1'b1, 8'h00, 8'd3);
    send_item(1'b1, 8'h00, 8'd255);
    send_item(1'b0, "W", 8'h00);
    send_item(1'b1, 8'h00, 8'd0);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_UNUSED;
    cfg_data_i <= 17'h1FFFF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    send_item(1'b1, 8'h00, 8'd0);

    idle_pct = 21;
    stall_pct = 21;
    configure(9'd511, 9'd2, 17'd0);
    load_alignment(2, 256, 10, 1'b0);
    ask_rows(2, 4);
    configure(9'd0, 9'd256, 17'h1FFFF);
    load_alignment(256, 1, 0, 1'b0);
    ask_rows(256, 4);
    configure(9'd7, 9'd0, 17'd65536);
    load_alignment(1, 7, 0, 1'b0);
    ask_rows(1, 3);
    configure(9'd3, 9'd300, 17'd52429);
    send_item(1'b1, 8'h00, 8'd0);
    configure(9'd5, 9'd6, 17'd0);
    load_alignment(6, 5, 30, 1'b0);
    ask_rows(6, 4);

    ph = 0;
    while (ph < 4 || sent < 1000) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      nr = $urandom_range(10, 1);
      nc = $urandom_range(12, 1);
      configure(9'(nc), 9'(nr), pick_threshold());
      if ($urandom_range(3) == 0) ask_rows(nr, 1);
      load_alignment(nr, nc, $urandom_range(60), $urandom_range(9) == 0);
      ask_rows(nr, $urandom_range(6, 2));
      if ($urandom_range(4) == 0) begin
        load_alignment(nr, nc, $urandom_range(60), 1'b0);
        ask_rows(nr, 3);
      end
      ph++;
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("msa_sequence_reweighting regression: pass");
    end else begin
      $display("msa_sequence_reweighting regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/msr_pkg.sv
sv/msr_div.sv
sv/msr_datapath.sv
sv/msr_ctrl.sv
sv/msa_sequence_reweighting.sv
verif/msr_checker.sv
verif/msa_sequence_reweighting_tb.sv
